// ----- hw/rtl/kdlp_pkg.sv -----
`default_nettype none
package kdlp_pkg;

  // fixed field widths
  localparam int unsigned LEVELS_W  = 10;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned EVENT_W   = 3;
  localparam int unsigned REPEAT_W  = 8;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned DEB_W     = 8;
  localparam int unsigned IDLE_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // default key count
  localparam int unsigned KEYS_DEFAULT = 10;

  // repeat-clearing window width above hold_max
  localparam logic [HOLD_W:0] REPEAT_WINDOW = (HOLD_W+1)'(2);

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE       = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DOWN       = 3'd1;
  localparam logic [EVENT_W-1:0] EV_HOLDING    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_SHORT_LONG = 3'd3;
  localparam logic [EVENT_W-1:0] EV_LONG       = 3'd4;
  localparam logic [EVENT_W-1:0] EV_PRESSED    = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LONG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_CLEAR = 3'd5;

  // register reset values
  localparam logic              LOOP_MODE_RST  = 1'b1;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST   = 8'd3;
  localparam logic [HOLD_W-1:0] HOLD_MAX_RST   = 16'd200;
  localparam logic [HOLD_W-1:0] SHORT_LONG_RST = 16'd100;
  localparam logic [HOLD_W-1:0] LONG_RST       = 16'd300;
  localparam logic [IDLE_W-1:0] IDLE_CLEAR_RST = 16'd50;

  typedef struct packed {
    logic              loop_mode;
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HOLD_W-1:0] hold_max;
    logic [HOLD_W-1:0] short_long_ticks;
    logic [HOLD_W-1:0] long_ticks;
    logic [IDLE_W-1:0] idle_clear_ticks;
  } cfg_t;

  // what one lane reports after a tick
  typedef struct packed {
    logic [EVENT_W-1:0]  key_event;
    logic [REPEAT_W-1:0] repeat_count;
    logic [HOLD_W-1:0]   hold_count;
  } lane_out_t;

endpackage
`default_nettype wire

// ----- hw/rtl/kdlp_if.sv -----
`default_nettype none
// scan tick channel
interface kdlp_in_if;
  logic                           valid;
  logic                           ready;
  logic [kdlp_pkg::LEVELS_W-1:0]  key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

// per-key result channel
interface kdlp_out_if;
  logic                           valid;
  logic                           ready;
  logic [kdlp_pkg::INDEX_W-1:0]   key_index;
  logic [kdlp_pkg::EVENT_W-1:0]   key_event;
  logic [kdlp_pkg::REPEAT_W-1:0]  repeat_count;
  logic [kdlp_pkg::HOLD_W-1:0]    hold_count;
  logic                           last_key;

  modport source (output valid, output key_index, output key_event, output repeat_count,
                  output hold_count, output last_key, input ready);
  modport sink   (input valid, input key_index, input key_event, input repeat_count,
                  input hold_count, input last_key, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/key_debounce_long_press.sv -----
// key_debounce_long_press: per-key debounce and long-press tracking
// the beat for key 0 is valid in the cycle after a scan tick is accepted
// one result beat per cycle from the lane mux while result_out.ready is high
// all key lanes update together in the accept cycle; the next tick may be taken
// in the cycle the last beat goes out
// reset (synchronous, rst high): keys idle, counts and events cleared, registers at defaults
`default_nettype none
module key_debounce_long_press #(
  parameter int unsigned KEYS = kdlp_pkg::KEYS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  kdlp_in_if.sink                                 key_in,
  kdlp_out_if.source                              result_out,
  input  wire logic                               cfg_we,
  input  wire logic [kdlp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kdlp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  kdlp_pkg::cfg_t      cfg;
  kdlp_pkg::lane_out_t lanes [KEYS];
  logic                can_start;
  logic                accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_mode        <= kdlp_pkg::LOOP_MODE_RST;
      cfg.debounce_ticks   <= kdlp_pkg::DEBOUNCE_RST;
      cfg.hold_max         <= kdlp_pkg::HOLD_MAX_RST;
      cfg.short_long_ticks <= kdlp_pkg::SHORT_LONG_RST;
      cfg.long_ticks       <= kdlp_pkg::LONG_RST;
      cfg.idle_clear_ticks <= kdlp_pkg::IDLE_CLEAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdlp_pkg::REG_LOOP_MODE:  cfg.loop_mode        <= cfg_data[0];
        kdlp_pkg::REG_DEBOUNCE:   cfg.debounce_ticks   <= cfg_data[kdlp_pkg::DEB_W-1:0];
        kdlp_pkg::REG_HOLD_MAX:   cfg.hold_max         <= cfg_data[kdlp_pkg::HOLD_W-1:0];
        kdlp_pkg::REG_SHORT_LONG: cfg.short_long_ticks <= cfg_data[kdlp_pkg::HOLD_W-1:0];
        kdlp_pkg::REG_LONG:       cfg.long_ticks       <= cfg_data[kdlp_pkg::HOLD_W-1:0];
        kdlp_pkg::REG_IDLE_CLEAR: cfg.idle_clear_ticks <= cfg_data[kdlp_pkg::IDLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign key_in.ready = can_start;
  assign accept       = key_in.valid && can_start;

  // one lane per key; keys beyond the input width read as released
  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    logic pressed;
    if (k < kdlp_pkg::LEVELS_W) begin : g_wired
      assign pressed = key_in.key_levels[k];
    end else begin : g_unwired
      assign pressed = 1'b0;
    end
    kdlp_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .step    (accept),
      .pressed (pressed),
      .cfg     (cfg),
      .result  (lanes[k])
    );
  end

  kdlp_merge #(.KEYS(KEYS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .can_start (can_start),
    .lanes     (lanes),
    .res       (result_out)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/kdlp_lane.sv -----
`default_nettype none
module kdlp_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic                pressed,
  input  wire kdlp_pkg::cfg_t      cfg,
  output kdlp_pkg::lane_out_t      result
);

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DEBOUNCE = 2'd1,
    ST_HELD     = 2'd2,
    ST_RELEASE  = 2'd3
  } state_t;

  state_t                            state, state_next;
  logic [kdlp_pkg::EVENT_W-1:0]      sticky, sticky_next;
  logic [kdlp_pkg::DEB_W-1:0]        deb, deb_next;
  logic [kdlp_pkg::HOLD_W-1:0]       hold, hold_next;
  logic [kdlp_pkg::REPEAT_W-1:0]     rep, rep_next;
  logic [kdlp_pkg::IDLE_W-1:0]       idle, idle_next;

  logic                              counted;
  logic                              settled;
  logic [kdlp_pkg::DEB_W-1:0]        deb_count;
  logic [kdlp_pkg::HOLD_W-1:0]       hold_inc;
  logic [kdlp_pkg::IDLE_W-1:0]       idle_inc;
  logic                              in_window;

  assign counted = cfg.loop_mode;

  // debounce counter, saturating at the threshold
  always_comb begin
    if (pressed && counted) begin
      if (deb < cfg.debounce_ticks) begin
        deb_count = deb + kdlp_pkg::DEB_W'(1);
      end else begin
        deb_count = deb;
      end
    end else begin
      deb_count = '0;
    end
  end

  assign settled  = !counted || (deb_count == cfg.debounce_ticks);
  assign hold_inc = (hold == '1) ? hold : hold + kdlp_pkg::HOLD_W'(1);
  assign idle_inc = idle + kdlp_pkg::IDLE_W'(1);
  assign in_window = (hold_inc >= cfg.hold_max) &&
                     ({1'b0, hold_inc} <= ({1'b0, cfg.hold_max} + kdlp_pkg::REPEAT_WINDOW));

  // next state of the key machine
  always_comb begin
    state_next  = state;
    sticky_next = sticky;
    deb_next    = deb_count;
    hold_next   = hold;
    rep_next    = rep;
    idle_next   = idle;
    unique case (state)
      ST_IDLE: begin
        if (pressed) begin
          if (counted) begin
            deb_next   = '0;
            state_next = ST_DEBOUNCE;
          end else begin
            hold_next  = '0;
            state_next = ST_HELD;
          end
        end else begin
          sticky_next = kdlp_pkg::EV_NONE;
          if (idle_inc >= cfg.idle_clear_ticks) begin
            idle_next = '0;
            rep_next  = '0;
          end else begin
            idle_next = idle_inc;
          end
        end
      end
      ST_DEBOUNCE: begin
        if (settled) begin
          if (pressed) begin
            state_next  = ST_HELD;
            sticky_next = kdlp_pkg::EV_DOWN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_HELD: begin
        if (pressed) begin
          sticky_next = kdlp_pkg::EV_HOLDING;
          if (settled) begin
            hold_next = hold_inc;
            if (in_window) begin
              rep_next = '0;
            end
            if (hold_inc >= cfg.long_ticks) begin
              sticky_next = kdlp_pkg::EV_LONG;
            end else if (hold_inc >= cfg.short_long_ticks) begin
              sticky_next = kdlp_pkg::EV_SHORT_LONG;
            end
          end
        end else begin
          state_next = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (rep != '1) begin
          rep_next = rep + kdlp_pkg::REPEAT_W'(1);
        end
        sticky_next = kdlp_pkg::EV_PRESSED;
        hold_next   = '0;
        idle_next   = '0;
        state_next  = ST_IDLE;
      end
    endcase
  end

  // per-key state, updated once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      sticky <= kdlp_pkg::EV_NONE;
      deb    <= '0;
      hold   <= '0;
      rep    <= '0;
      idle   <= '0;
    end else if (step) begin
      state  <= state_next;
      sticky <= sticky_next;
      deb    <= deb_next;
      hold   <= hold_next;
      rep    <= rep_next;
      idle   <= idle_next;
    end
  end

  assign result.key_event    = sticky;
  assign result.repeat_count = rep;
  assign result.hold_count   = hold;

endmodule
`default_nettype wire

// ----- hw/rtl/kdlp_merge.sv -----
`default_nettype none
module kdlp_merge #(
  parameter int unsigned KEYS = kdlp_pkg::KEYS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      can_start,
  input  wire kdlp_pkg::lane_out_t  lanes [KEYS],
  kdlp_out_if.source                res
);

  localparam int unsigned IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEYS - 1);

  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             last;
  logic             beat;

  assign last      = (idx == LAST_IDX);
  assign beat      = busy && res.ready;
  assign can_start = !busy || (res.ready && last);

  // walk the lanes one beat per cycle while res.ready is high; a new tick restarts the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (beat) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  // result beat from the selected lane
  assign res.valid        = busy;
  assign res.key_index    = kdlp_pkg::INDEX_W'(idx);
  assign res.key_event    = lanes[idx].key_event;
  assign res.repeat_count = lanes[idx].repeat_count;
  assign res.hold_count   = lanes[idx].hold_count;
  assign res.last_key     = last;

endmodule
`default_nettype wire

// ----- hw/rtl/kdlp_checker.sv -----
`default_nettype none
module kdlp_checker #(
  parameter int unsigned KEYS = kdlp_pkg::KEYS_DEFAULT
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [kdlp_pkg::INDEX_W-1:0]  key_index,
  input wire logic                          last_key
);

  // a stalled beat keeps its key
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_index))
    else $error("result beat changed while stalled");

  // a tick starts with key 0
  a_first_key: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid && (key_index == '0))
    else $error("tick did not start at key 0");

  // keys of a tick follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_key |=> out_valid &&
      (key_index == $past(key_index) + kdlp_pkg::INDEX_W'(1)))
    else $error("gap or skip in key sequence");

  // last flag marks the final key
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_key == (key_index == kdlp_pkg::INDEX_W'(KEYS - 1))))
    else $error("last flag on wrong key");

  // no new tick while the current one still has beats to go
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(out_ready && last_key) |-> !in_ready)
    else $error("tick taken while results pending");

endmodule

bind key_debounce_long_press kdlp_checker #(.KEYS(KEYS)) u_kdlp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (key_in.valid),
  .in_ready  (key_in.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .key_index (result_out.key_index),
  .last_key  (result_out.last_key)
);
`default_nettype wire
